### rtl/pausable_oneshot_timer_top_macros.svh
// assertion helpers for the timer rtl
`ifndef PAUSABLE_ONESHOT_TIMER_TOP_MACROS_SVH
`define PAUSABLE_ONESHOT_TIMER_TOP_MACROS_SVH

// condition now implies consequence in the same cycle
`define POT_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition now implies consequence in the next cycle
`define POT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pot_pkg.sv
`default_nettype none

package pot_pkg;

  // default width of the internal tick arithmetic
  localparam int TIME_WIDTH_DEF = 32;

  // fixed field widths on the ports
  localparam int OP_W   = 3;
  localparam int DUR_W  = 32;
  localparam int MODE_W = 2;
  localparam int OUT_W  = 32;

  // operation codes; the two top codes are unused
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_RESTART = 3'd2,
    OP_STOP    = 3'd3,
    OP_PAUSE   = 3'd4,
    OP_RESUME  = 3'd5
  } op_t;

  // timer modes; code 3 is unused
  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BUSY   = 2'd1,
    MODE_PAUSED = 2'd2
  } mode_t;

  // one result beat
  typedef struct packed {
    mode_t            mode;
    logic [OUT_W-1:0] remaining;
    logic [OUT_W-1:0] elapsed;
    logic             expired;
  } res_t;

endpackage

`default_nettype wire

### rtl/pot_step.sv
`default_nettype none

`include "pausable_oneshot_timer_top_macros.svh"

module pot_step #(
  parameter int TIME_WIDTH = pot_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  pot_pkg::op_t                op,
  input  logic [pot_pkg::DUR_W-1:0]   dur,
  output pot_pkg::res_t               res
);
  import pot_pkg::*;

  // timer state
  logic [TIME_WIDTH-1:0] now_ticks;
  logic [TIME_WIDTH-1:0] start_tick;
  logic [TIME_WIDTH-1:0] run_length;
  mode_t                 timer_mode;

  logic [TIME_WIDTH-1:0] now_ticks_next;
  logic [TIME_WIDTH-1:0] start_tick_next;
  logic [TIME_WIDTH-1:0] run_length_next;
  mode_t                 timer_mode_next;

  logic [TIME_WIDTH-1:0] dur_t;
  logic [TIME_WIDTH-1:0] el_cur;
  logic [TIME_WIDTH-1:0] rem_cur;
  logic [TIME_WIDTH-1:0] el_tick;
  logic [TIME_WIDTH-1:0] rem_tick;
  logic                  expire_hit;
  logic [TIME_WIDTH-1:0] cur_rem;
  logic [TIME_WIDTH-1:0] cur_el;
  logic [TIME_WIDTH-1:0] rem_w;
  logic [TIME_WIDTH-1:0] el_w;

  // elapsed and remaining before and after a tick
  assign dur_t      = TIME_WIDTH'(dur);
  assign el_cur     = now_ticks - start_tick;
  assign rem_cur    = run_length - el_cur;
  assign el_tick    = el_cur + TIME_WIDTH'(1);
  assign rem_tick   = run_length - el_tick;
  assign expire_hit = (op == OP_TICK) && (timer_mode == MODE_BUSY) && (el_tick >= run_length);

  // report for the unchanged state
  always_comb begin
    cur_rem = '0;
    cur_el  = '0;
    if (timer_mode == MODE_BUSY) begin
      cur_rem = rem_cur;
      cur_el  = el_cur;
    end else if (timer_mode == MODE_PAUSED) begin
      cur_rem = run_length;
    end
  end

  // next state
  always_comb begin
    now_ticks_next  = now_ticks;
    start_tick_next = start_tick;
    run_length_next = run_length;
    timer_mode_next = timer_mode;
    unique case (op)
      OP_TICK: begin
        now_ticks_next = now_ticks + TIME_WIDTH'(1);
        if (expire_hit) begin
          start_tick_next = '0;
          run_length_next = '0;
          timer_mode_next = MODE_IDLE;
        end
      end
      OP_START: begin
        if (timer_mode == MODE_IDLE) begin
          start_tick_next = now_ticks;
          run_length_next = dur_t;
          timer_mode_next = MODE_BUSY;
        end
      end
      OP_RESTART: begin
        start_tick_next = now_ticks;
        run_length_next = dur_t;
        timer_mode_next = MODE_BUSY;
      end
      OP_STOP: begin
        start_tick_next = '0;
        run_length_next = '0;
        timer_mode_next = MODE_IDLE;
      end
      OP_PAUSE: begin
        if (timer_mode == MODE_BUSY) begin
          run_length_next = rem_cur;
          start_tick_next = '0;
          timer_mode_next = MODE_PAUSED;
        end
      end
      OP_RESUME: begin
        if (timer_mode == MODE_PAUSED) begin
          start_tick_next = now_ticks;
          timer_mode_next = MODE_BUSY;
        end
      end
      default: begin
      end
    endcase
  end

  // result for this step, taken from the state it leaves
  always_comb begin
    rem_w = cur_rem;
    el_w  = cur_el;
    unique case (op)
      OP_TICK: begin
        if (timer_mode == MODE_BUSY) begin
          rem_w = expire_hit ? '0 : rem_tick;
          el_w  = expire_hit ? '0 : el_tick;
        end
      end
      OP_START: begin
        if (timer_mode == MODE_IDLE) begin
          rem_w = dur_t;
          el_w  = '0;
        end
      end
      OP_RESTART: begin
        rem_w = dur_t;
        el_w  = '0;
      end
      OP_STOP: begin
        rem_w = '0;
        el_w  = '0;
      end
      OP_PAUSE: begin
        if (timer_mode == MODE_BUSY) begin
          rem_w = rem_cur;
          el_w  = '0;
        end
      end
      OP_RESUME: begin
        if (timer_mode == MODE_PAUSED) begin
          rem_w = run_length;
          el_w  = '0;
        end
      end
      default: begin
      end
    endcase
    res.mode      = timer_mode_next;
    res.remaining = OUT_W'(rem_w);
    res.elapsed   = OUT_W'(el_w);
    res.expired   = expire_hit;
  end

  // state update once per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks  <= '0;
      start_tick <= '0;
      run_length <= '0;
      timer_mode <= MODE_IDLE;
    end else if (fire) begin
      now_ticks  <= now_ticks_next;
      start_tick <= start_tick_next;
      run_length <= run_length_next;
      timer_mode <= timer_mode_next;
    end
  end

  // checks
  `POT_ASSERT_NEXT(a_stop_clears, clk, rst, fire && op == OP_STOP,
    timer_mode == MODE_IDLE && run_length == '0 && start_tick == '0, "stop left state behind")
  `POT_ASSERT_NEXT(a_pause_holds, clk, rst,
    fire && op == OP_TICK && timer_mode == MODE_PAUSED,
    timer_mode == MODE_PAUSED && run_length == $past(run_length), "paused timer moved")
  `POT_ASSERT_NEXT(a_idle_time, clk, rst, !fire, $stable(now_ticks) && $stable(timer_mode),
    "state changed without a beat")
  `POT_ASSERT_NOW(a_expire_idle, clk, rst, fire && res.expired,
    res.mode == MODE_IDLE && timer_mode == MODE_BUSY, "expiry outside busy")

endmodule

`default_nettype wire

### rtl/pausable_oneshot_timer_top.sv
// pausable one-shot timer
// path: an accepted command beat is held in the input register, and its result is
//   captured in the result register when the beat fires
// throughput: one command per cycle while rsp_stall does not hold the result register
// reset: synchronous, clears tick counter, start, run length, mode (idle) and both valids
`default_nettype none

module pausable_oneshot_timer_top #(
  parameter int TIME_WIDTH = pot_pkg::TIME_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [pot_pkg::OP_W-1:0]     operation,
  input  logic [pot_pkg::DUR_W-1:0]    duration,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [pot_pkg::MODE_W-1:0]   mode,
  output logic [pot_pkg::OUT_W-1:0]    remaining,
  output logic [pot_pkg::OUT_W-1:0]    elapsed,
  output logic                         expired
);
  import pot_pkg::*;

  logic             s1_valid;
  op_t              s1_op;
  logic [DUR_W-1:0] s1_dur;
  logic             advance;
  logic             fire;
  logic             cmd_accept;
  res_t             step_res;
  res_t             rsp_res;

  // handshake control
  assign advance    = !rsp_valid || !rsp_stall;
  assign fire       = s1_valid && advance;
  assign cmd_stall  = s1_valid && !advance;
  assign cmd_accept = cmd_valid && !cmd_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      s1_op  <= op_t'(operation);
      s1_dur <= duration;
    end
  end

  // timer state and step logic
  pot_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .op   (s1_op),
    .dur  (s1_dur),
    .res  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_res <= step_res;
    end
  end

  assign mode      = rsp_res.mode;
  assign remaining = rsp_res.remaining;
  assign elapsed   = rsp_res.elapsed;
  assign expired   = rsp_res.expired;

endmodule

`default_nettype wire
